// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the MD5 compression design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/md5c_pkg.sv =====
// ----------------------------------------------------------------------------
// md5c_pkg
// Types, constants and round tables for the MD5 block compression engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package md5c_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int ROUNDS      = 64;

   // Standard initial chaining values
   localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
   localparam logic [WORD_W-1:0] INIT_B = 32'hefcdab89;
   localparam logic [WORD_W-1:0] INIT_C = 32'h98badcfe;
   localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;

   typedef struct packed {
      logic [WORD_W-1:0] message_word;
      logic              start_of_message;
      logic              end_of_message;
   } req_word_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_a;
      logic [WORD_W-1:0] digest_b;
      logic [WORD_W-1:0] digest_c;
      logic [WORD_W-1:0] digest_d;
   } rsp_word_type;

   // Additive round constants
   localparam logic [WORD_W-1:0] ROUND_CONST [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Left-rotate amount per round: group in bits 5:4, position in bits 1:0
   function automatic logic [4:0] rot_amount(input logic [5:0] r);
      logic [4:0] amt;
      case ({r[5:4], r[1:0]})
         4'b0000: amt = 5'd7;
         4'b0001: amt = 5'd12;
         4'b0010: amt = 5'd17;
         4'b0011: amt = 5'd22;
         4'b0100: amt = 5'd5;
         4'b0101: amt = 5'd9;
         4'b0110: amt = 5'd14;
         4'b0111: amt = 5'd20;
         4'b1000: amt = 5'd4;
         4'b1001: amt = 5'd11;
         4'b1010: amt = 5'd16;
         4'b1011: amt = 5'd23;
         4'b1100: amt = 5'd6;
         4'b1101: amt = 5'd10;
         4'b1110: amt = 5'd15;
         4'b1111: amt = 5'd21;
         default: amt = 5'd0;
      endcase
      return amt;
   endfunction

   // Message word index used by each round
   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [8:0] rr;
      logic [8:0] tmp;
      rr = {3'b000, r};
      case (r[5:4])
         2'd0:    tmp = rr;
         2'd1:    tmp = 9'd5 * rr + 9'd1;
         2'd2:    tmp = 9'd3 * rr + 9'd5;
         2'd3:    tmp = 9'd7 * rr;
         default: tmp = rr;
      endcase
      return tmp[3:0];
   endfunction

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input logic [4:0] n);
      logic [2*WORD_W-1:0] dbl;
      dbl = {x, x} << n;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

endpackage

// ===== design/md5c_ram.sv =====
// ----------------------------------------------------------------------------
// md5c_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module md5c_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/md5_block_compression.sv =====
// ----------------------------------------------------------------------------
// md5_block_compression
// MD5 compression over a padded word stream, digest strobed per final block.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while busy is low. The sixteenth word of a
// block raises busy while the block is compressed: a priming step starts the
// first block RAM read, then come the rounds (one round per cycle through the
// single round unit, each fed by one registered read of the block RAM), and a
// final step folds the result into the chaining values. When the block's last
// word carries end_of_message, the digest appears on rsp_word for exactly one
// cycle with rsp_strobe high, in the cycle busy falls; there is no way to
// hold it off, so capture it then.
`timescale 1ns / 1ps

module md5_block_compression (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  md5c_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output md5c_pkg::rsp_word_type rsp_word
);

`include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   localparam int W = md5c_pkg::WORD_W;

   logic [1:0]   state_ff, state_in;
   logic [3:0]   count_ff, count_in;
   logic [6:0]   issue_ff, issue_in;
   logic         end_ff, end_in;
   logic [W-1:0] a_ff, b_ff, c_ff, d_ff;
   logic [W-1:0] a_in, b_in, c_in, d_in;
   logic [W-1:0] cv_ff [4];
   logic [W-1:0] cv_in [4];
   logic         rsp_strobe_ff, rsp_strobe_in;
   md5c_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic         accept;
   logic [3:0]   wr_index;
   logic         last_word;
   logic [3:0]   rd_addr;
   logic [W-1:0] msg_data;
   logic [5:0]   round_idx;
   logic [W-1:0] f_val;
   logic [W-1:0] round_sum;
   logic [W-1:0] b_new;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start & ~busy;
   assign wr_index = req_word.start_of_message ? 4'd0 : count_ff;
   assign last_word = (wr_index == 4'd15);

   // Read the word for the round after the one in flight
   assign rd_addr = md5c_pkg::msg_index(issue_ff[5:0]);

   md5c_ram #(
      .WIDTH (md5c_pkg::WORD_W),
      .DEPTH (md5c_pkg::BLOCK_WORDS)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_index),
      .wr_data (req_word.message_word),
      .rd_addr (rd_addr),
      .rd_data (msg_data)
   );

   // Round datapath: round issue-1 consumes the word read last cycle
   assign round_idx = issue_ff[5:0] - 6'd1;

   always_comb begin
      case (round_idx[5:4])
         2'd0:    f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f_val = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         2'd3:    f_val = c_ff ^ (b_ff | ~d_ff);
         default: f_val = '0;
      endcase
   end

   assign round_sum = a_ff + f_val + md5c_pkg::ROUND_CONST[round_idx] + msg_data;
   assign b_new     = b_ff + md5c_pkg::rotl(round_sum, md5c_pkg::rot_amount(round_idx));

   // Sequencer and next-state logic
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      end_in        = end_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      d_in          = d_ff;
      cv_in         = cv_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.start_of_message) begin
                  cv_in[0] = md5c_pkg::INIT_A;
                  cv_in[1] = md5c_pkg::INIT_B;
                  cv_in[2] = md5c_pkg::INIT_C;
                  cv_in[3] = md5c_pkg::INIT_D;
               end
               if (last_word) begin
                  count_in = 4'd0;
                  state_in = ST_ROUND;
                  issue_in = 7'd0;
                  end_in   = req_word.end_of_message;
                  a_in     = cv_ff[0];
                  b_in     = cv_ff[1];
                  c_in     = cv_ff[2];
                  d_in     = cv_ff[3];
               end else begin
                  count_in = wr_index + 4'd1;
               end
            end
         end
         ST_ROUND: begin
            issue_in = issue_ff + 7'd1;
            if (issue_ff != 7'd0) begin
               a_in = d_ff;
               d_in = c_ff;
               c_in = b_ff;
               b_in = b_new;
            end
            if (issue_ff == 7'(md5c_pkg::ROUNDS)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cv_in[0] = cv_ff[0] + a_ff;
            cv_in[1] = cv_ff[1] + b_ff;
            cv_in[2] = cv_ff[2] + c_ff;
            cv_in[3] = cv_ff[3] + d_ff;
            rsp_word_in.digest_a = cv_in[0];
            rsp_word_in.digest_b = cv_in[1];
            rsp_word_in.digest_c = cv_in[2];
            rsp_word_in.digest_d = cv_in[3];
            rsp_strobe_in = end_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= 4'd0;
         issue_ff      <= 7'd0;
         end_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         cv_ff[0]      <= md5c_pkg::INIT_A;
         cv_ff[1]      <= md5c_pkg::INIT_B;
         cv_ff[2]      <= md5c_pkg::INIT_C;
         cv_ff[3]      <= md5c_pkg::INIT_D;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         end_ff        <= end_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cv_ff         <= cv_in;
      end
   end

   // Working variables and result word
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // Checks
   `ASSERT_NEXT(a_last_word_busy, clock, reset, accept && last_word, busy, "last word did not start rounds")
   `ASSERT_IMPL(a_strobe_idle, clock, reset, rsp_strobe, !busy, "digest strobed while busy")
   `ASSERT_IMPL(a_strobe_src, clock, reset, rsp_strobe, $past(state_ff) == ST_FINAL, "digest without final add")
   `ASSERT_IMPL(a_issue_range, clock, reset, state_ff == ST_ROUND, issue_ff <= 7'(md5c_pkg::ROUNDS), "round counter overrun")

endmodule

// ===== bench/md5_block_compression_tb.sv =====
// ----------------------------------------------------------------------------
// md5_block_compression_tb
// Self-checking bench for the MD5 block compression engine. Padded message
// words are pushed through the start/busy command port while a behavioral
// MD5 model tracks the chaining state, and every strobed digest is compared
// field by field against the oldest predicted digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module md5_block_compression_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 80;

   // MD5 additive constants, one per round
   localparam logic [31:0] ADD_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // rotate amounts: row = round group, column = round mod 4
   localparam int ROT_BY [16] = '{
      7, 12, 17, 22,
      5,  9, 14, 20,
      4, 11, 16, 23,
      6, 10, 15, 21
   };

   localparam logic [31:0] MD5_IV [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   md5c_pkg::req_word_type req_word = '0;
   logic                   rsp_strobe;
   md5c_pkg::rsp_word_type rsp_word;

   // model state
   logic [31:0]  msg_block [16];
   logic [31:0]  chain [4];
   logic [3:0]   word_pos;

   md5c_pkg::rsp_word_type expected_digests [$];
   int           words_sent;
   int           mismatches = 0;
   int           sender_idle_pct;
   int           stalled_cycles = 0;

   md5_block_compression dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // MD5 model
   // ------------------------------------------------------------------------

   // 64 rounds over the buffered block, folded into the chaining words
   function automatic void md5_compress();
      logic [31:0] a, b, c, d, f, t, sum;
      logic [5:0]  ri;
      logic [3:0]  g;
      int          s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
         ri = 6'(r);
         case (ri[5:4])
            2'd0: begin
               f = (b & c) | (~b & d);
               g = ri[3:0];
            end
            2'd1: begin
               f = (d & b) | (~d & c);
               g = 4'(5 * r + 1);
            end
            2'd2: begin
               f = b ^ c ^ d;
               g = 4'(3 * r + 5);
            end
            default: begin
               f = c ^ (b | ~d);
               g = 4'(7 * r);
            end
         endcase
         s   = ROT_BY[{ri[5:4], ri[1:0]}];
         sum = a + f + ADD_CONST[ri] + msg_block[g];
         t   = d;
         d   = c;
         c   = b;
         b   = b + ((sum << s) | (sum >> (32 - s)));
         a   = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
   endfunction

   // one accepted word; queues a digest when a final block completes
   function automatic void md5_absorb_word(input md5c_pkg::req_word_type item);
      md5c_pkg::rsp_word_type digest;
      if (item.start_of_message) begin
         chain    = MD5_IV;
         word_pos = 4'd0;
      end
      msg_block[word_pos] = item.message_word;
      if (word_pos == 4'd15) begin
         word_pos = 4'd0;
         md5_compress();
         if (item.end_of_message) begin
            digest.digest_a = chain[0];
            digest.digest_b = chain[1];
            digest.digest_c = chain[2];
            digest.digest_d = chain[3];
            expected_digests.push_back(digest);
         end
      end else begin
         word_pos++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driver
   // ------------------------------------------------------------------------

   // hold the word until busy is low at a clock edge, then maybe go idle
   task automatic send_word(input logic [31:0] w, input logic som, input logic eom);
      md5c_pkg::req_word_type item;
      int                     gap;
      item.message_word     = w;
      item.start_of_message = som;
      item.end_of_message   = eom;
      start    <= 1'b1;
      req_word <= item;
      do @(posedge clock); while (busy !== 1'b0);
      md5_absorb_word(item);
      words_sent++;
      if ($urandom_range(99) < sender_idle_pct) begin
         // mostly short gaps, some long enough to span a whole compression
         gap = ($urandom_range(3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(9))
         0:       return 32'h0;
         1:       return 32'hffffffff;
         default: return $urandom();
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      md5c_pkg::rsp_word_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_digests.size() == 0) begin
            $display("%0t: unexpected digest, expected none, actual %h", $realtime,
                     rsp_word);
            mismatches++;
         end else begin
            want = expected_digests.pop_front();
            check_field("digest_a", want.digest_a, rsp_word.digest_a);
            check_field("digest_b", want.digest_b, rsp_word.digest_b);
            check_field("digest_c", want.digest_c, rsp_word.digest_c);
            check_field("digest_d", want.digest_d, rsp_word.digest_d);
         end
      end
   end

   // watchdog: cycles with neither a word taken nor a digest strobed
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d digests outstanding", $realtime,
                  expected_digests.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // no start flag after reset: hashing begins from the reset chaining values
   task automatic test_no_start_after_reset();
      logic [31:0] w;
      for (int i = 0; i < 16; i++) begin
         case (i % 4)
            0:       w = 32'h0;
            1:       w = 32'hffffffff;
            2:       w = 32'h80000000;
            default: w = 32'h00000001;
         endcase
         send_word(w, 1'b0, i == 15);
      end
   endtask

   // keep hashing from the emitted digest; early end flags must be ignored
   task automatic test_continue_after_digest();
      for (int i = 0; i < 16; i++) begin
         send_word(random_word(), 1'b0, i == 0 || i == 7 || i == 15);
      end
   endtask

   // start in mid-block drops the partial block; then the empty-message block
   task automatic test_restart_mid_block();
      for (int i = 0; i < 5; i++) begin
         send_word(32'hffffffff, i == 0, 1'b1);
      end
      for (int i = 0; i < 16; i++) begin
         send_word((i == 0) ? 32'h00000080 : 32'h0, i == 0, 1'b1);
      end
   endtask

   // mostly well-formed messages, plus abandoned and unstarted fragments
   task automatic random_message();
      int kind;
      int nblocks;
      int nwords;
      bit last;
      bit eom;
      kind = $urandom_range(99);
      if (kind < 80) begin
         nblocks = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
         for (int blk = 0; blk < nblocks; blk++) begin
            last = (blk == nblocks - 1);
            for (int i = 0; i < 16; i++) begin
               if (i == 15) eom = last;
               else eom = last ? 1'($urandom_range(1)) : ($urandom_range(7) == 0);
               send_word(random_word(), blk == 0 && i == 0, eom);
            end
         end
      end else if (kind < 90) begin
         nwords = $urandom_range(1, 15);
         for (int i = 0; i < nwords; i++) begin
            send_word(random_word(), i == 0, 1'($urandom_range(1)));
         end
      end else begin
         for (int i = 0; i < 16; i++) begin
            eom = (i == 15) ? 1'($urandom_range(1)) : ($urandom_range(3) == 0);
            send_word(random_word(), 1'b0, eom);
         end
      end
   endtask

   task automatic test_random_messages(input int idle_pct, input int n_words);
      int words_at_start;
      words_at_start   = words_sent;
      sender_idle_pct  = idle_pct;
      while (words_sent - words_at_start < n_words) begin
         random_message();
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      chain             = MD5_IV;
      word_pos          = 4'd0;
      words_sent        = 0;
      sender_idle_pct   = 0;
      msg_block         = '{default: '0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_no_start_after_reset();
      test_continue_after_digest();
      test_restart_mid_block();
      test_random_messages(0, 300);
      test_random_messages(68, 300);
      test_random_messages(12, 300);

      start <= 1'b0;
      while (expected_digests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/md5c_pkg.sv
design/md5c_ram.sv
design/md5_block_compression.sv
bench/md5_block_compression_tb.sv
